/* sv/b64sc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_pkg: shared types and alphabet functions
// Burst record passed from the step logic to the result serializer, plus
// the base64 character encode and decode tables.
// ----------------------------------------------------------------------------
package b64sc_pkg;

   localparam int BURST_MAX = 4;
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;
   localparam logic [1:0] POS_FOURTH = 2'd3;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] data;
      logic [2:0]                count;
      logic                      err;
      logic                      last;
   } burst_type;

   function automatic logic [7:0] enc_char(input logic [5:0] six);
      logic [7:0] s;
      s = {2'b00, six};
      if (six < 6'd26)      return 8'h41 + s;
      else if (six < 6'd52) return 8'h61 + s - 8'd26;
      else if (six < 6'd62) return 8'h30 + s - 8'd52;
      else if (six == 6'd62) return 8'h2B;
      else return 8'h2F;
   endfunction

   // {valid, six-bit value}
   function automatic logic [6:0] dec_char(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A)      return {1'b1, 6'(c - 8'h41)};
      else if (c >= 8'h61 && c <= 8'h7A) return {1'b1, 6'(c - 8'h61 + 8'd26)};
      else if (c >= 8'h30 && c <= 8'h39) return {1'b1, 6'(c - 8'h30 + 8'd52)};
      else if (c == 8'h2B)               return {1'b1, 6'd62};
      else if (c == 8'h2F)               return {1'b1, 6'd63};
      else return 7'd0;
   endfunction

endpackage

/* sv/b64sc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_core: input register, stream state and per-beat step logic
// Holds one input beat, computes its burst of results and the next stream
// state, and hands the burst to the serializer when it can take it.
// ----------------------------------------------------------------------------
module b64sc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 direction,
   input  logic                 clear,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   input  logic                 load_ok,
   output logic                 push,
   output b64sc_pkg::burst_type burst
);

   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff;
   logic        last_ff;

   logic [1:0]  pos_ff, pos_in;
   logic [17:0] held_ff, held_in;
   logic [2:0]  hval_ff, hval_in;
   logic        errs_ff, errs_in;

   logic [6:0]  dec;
   logic        ok;
   logic [5:0]  six;
   logic [23:0] word;
   logic [11:0] ev;
   logic        third;

   assign push     = valid_ff && load_ok;
   assign in_ready = !valid_ff || load_ok;
   assign valid_in = (in_valid && in_ready) ? 1'b1 : (push ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
         last_ff <= in_last;
      end
   end

   always_comb begin
      dec     = b64sc_pkg::dec_char(byte_ff);
      ok      = dec[6];
      six     = dec[5:0];
      word    = {held_ff, six};
      ev      = {held_ff[3:0], byte_ff};
      third   = hval_ff[2];
      pos_in  = pos_ff;
      held_in = held_ff;
      hval_in = hval_ff;
      errs_in = errs_ff;
      burst   = '0;
      if (direction == b64sc_pkg::DIR_ENCODE) begin
         unique case (pos_ff)
            b64sc_pkg::POS_FIRST: begin
               burst.data[0] = b64sc_pkg::enc_char(byte_ff[7:2]);
               held_in = {16'd0, byte_ff[1:0]};
               pos_in  = b64sc_pkg::POS_SECOND;
               if (last_ff) begin
                  burst.data[1] = b64sc_pkg::enc_char({byte_ff[1:0], 4'd0});
                  burst.data[2] = b64sc_pkg::PAD_CHAR;
                  burst.data[3] = b64sc_pkg::PAD_CHAR;
                  burst.count   = 3'd4;
               end else begin
                  burst.count   = 3'd1;
               end
            end
            b64sc_pkg::POS_SECOND: begin
               burst.data[0] = b64sc_pkg::enc_char({held_ff[1:0], byte_ff[7:4]});
               held_in = {14'd0, byte_ff[3:0]};
               pos_in  = b64sc_pkg::POS_THIRD;
               if (last_ff) begin
                  burst.data[1] = b64sc_pkg::enc_char({byte_ff[3:0], 2'd0});
                  burst.data[2] = b64sc_pkg::PAD_CHAR;
                  burst.count   = 3'd3;
               end else begin
                  burst.count   = 3'd1;
               end
            end
            default: begin
               burst.data[0] = b64sc_pkg::enc_char(ev[11:6]);
               burst.data[1] = b64sc_pkg::enc_char(ev[5:0]);
               burst.count   = 3'd2;
               held_in = '0;
               pos_in  = b64sc_pkg::POS_FIRST;
            end
         endcase
         burst.last = last_ff;
      end else if (errs_ff) begin
         if (last_ff) begin
            burst.count = 3'd1;
            burst.err   = 1'b1;
            burst.last  = 1'b1;
         end
      end else if (pos_ff != b64sc_pkg::POS_FOURTH) begin
         if (last_ff) begin
            burst.count = 3'd1;
            burst.err   = 1'b1;
            burst.last  = 1'b1;
         end else begin
            unique case (pos_ff)
               b64sc_pkg::POS_FIRST:  held_in[17:12] = six;
               b64sc_pkg::POS_SECOND: held_in[11:6]  = six;
               default:               held_in[5:0]   = six;
            endcase
            hval_in[pos_ff] = ok;
            pos_in = pos_ff + 2'd1;
         end
      end else begin
         pos_in  = b64sc_pkg::POS_FIRST;
         held_in = '0;
         hval_in = '0;
         burst.last = last_ff;
         if (hval_ff[1:0] != 2'b11) begin
            burst.count = 3'd1;
            burst.err   = 1'b1;
            errs_in     = 1'b1;
         end else begin
            burst.data[0] = word[23:16];
            burst.data[1] = third ? word[15:8] : word[7:0];
            burst.data[2] = word[7:0];
            burst.count   = 3'd1 + {2'd0, third} + {2'd0, ok};
         end
      end
      if (last_ff) begin
         pos_in  = '0;
         held_in = '0;
         hval_in = '0;
         errs_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         pos_ff  <= '0;
         held_ff <= '0;
         hval_ff <= '0;
         errs_ff <= 1'b0;
      end else if (push) begin
         pos_ff  <= pos_in;
         held_ff <= held_in;
         hval_ff <= hval_in;
         errs_ff <= errs_in;
      end
   end

endmodule

/* sv/b64sc_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_emit: result burst serializer
// Holds one burst of up to four results and sends them one beat per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module b64sc_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64sc_pkg::burst_type burst,
   output logic                 load_ok,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [7:0]           out_byte,
   output logic                 out_error,
   output logic                 out_last
);

   logic [b64sc_pkg::BURST_MAX-1:0][7:0] data_ff;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   logic       err_ff;
   logic       last_ff;
   logic       load;

   assign out_valid = cnt_ff != 3'd0;
   assign out_byte  = data_ff[idx_ff];
   assign out_error = err_ff;
   assign out_last  = last_ff && (cnt_ff == 3'd1);
   assign load_ok   = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && out_ready);
   assign load      = push && (burst.count != 3'd0);

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = burst.count;
         idx_in = '0;
      end else if (out_valid && out_ready) begin
         cnt_in = cnt_ff - 3'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
      if (load) begin
         data_ff <= burst.data;
         err_ff  <= burst.err;
         last_ff <= burst.last;
      end
   end

endmodule

/* sv/base64_stream_codec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec: streaming base64 encoder / decoder
// Standard alphabet with '=' padding; direction set through the csr port.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat per byte (encode) or character (decode);
//     req_tlast marks the final beat of a message.
//   rsp_ channel: one beat per output character or byte; rsp_tuser flags a
//     decode error (data zero), rsp_tlast closes the message.
//   csr_ port: register 0 (address 0) is direction, 0 encode, 1 decode.
//     Writing it also clears the stream state; write only while idle.
// A request beat is registered, then its results load the four-entry burst
//   buffer when free and leave one beat per cycle while rsp_tready is high.
// Throughput: an item holds the burst buffer until its results (0 to 4)
//   have all left; encode averages 4 results per 3 bytes, decode
//   up to 3 bytes per 4 characters. The input register takes a new beat
//   while the last result of the previous burst is leaving.
// Reset clears direction (encode), the stream state and both channels.
// A stalled receiver holds the current result; the input register then
//   fills and req_tready drops until the burst drains.
// ----------------------------------------------------------------------------
module base64_stream_codec (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // [0] out_error
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic REG_DIRECTION = 1'b0;

   logic                 dir_ff;
   logic                 wr_dir;
   logic                 push;
   logic                 load_ok;
   b64sc_pkg::burst_type burst;

   assign csr_pready = 1'b1;
   assign wr_dir = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_DIRECTION);
   assign csr_prdata = (csr_paddr[2] == REG_DIRECTION) ? {31'd0, dir_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= b64sc_pkg::DIR_ENCODE;
      end else if (wr_dir) begin
         dir_ff <= csr_pwdata[0];
      end
   end

   b64sc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .direction (dir_ff),
      .clear     (wr_dir),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .load_ok   (load_ok),
      .push      (push),
      .burst     (burst)
   );

   b64sc_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .burst     (burst),
      .load_ok   (load_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_error (rsp_tuser),
      .out_last  (rsp_tlast)
   );

endmodule

/* sv/b64sc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_checker: port-level checks for the base64 codec
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module b64sc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("error beat with nonzero data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no result pending");

endmodule

bind base64_stream_codec b64sc_checker u_b64sc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for base64_stream_codec
// Encode and decode messages are streamed through the req_ channel under
// random and long back-pressure. A scoreboard predicts every rsp_ beat from
// its own model of the codec, and checks each received beat in order.
// ----------------------------------------------------------------------------
typedef struct packed {
   logic [7:0] data;
   logic       err;
   logic       last;
} codec_beat_type;

class base64_scoreboard;
   string          alphabet;
   logic           direction;
   logic [1:0]     group_pos;
   logic [17:0]    held;
   logic [2:0]     held_ok;
   logic           error_seen;
   codec_beat_type expected_beats[$];
   int             mismatches;

   function new();
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      direction = b64sc_pkg::DIR_ENCODE;
      mismatches = 0;
      clear_stream();
   endfunction

   function void clear_stream();
      group_pos = b64sc_pkg::POS_FIRST;
      held = '0;
      held_ok = '0;
      error_seen = 1'b0;
   endfunction

   function void set_direction(logic value);
      direction = value;
      clear_stream();
   endfunction

   function logic [7:0] char_of(logic [5:0] six);
      return alphabet[int'(six)];
   endfunction

   function int pending();
      return expected_beats.size();
   endfunction

   function void push(logic [7:0] data, logic err, logic last_flag);
      codec_beat_type beat;
      beat.data = data;
      beat.err = err;
      beat.last = last_flag;
      expected_beats.push_back(beat);
   endfunction

   function void encode_byte(logic [7:0] b, logic last_flag);
      logic [9:0]  v10;
      logic [11:0] v12;
      case (group_pos)
         b64sc_pkg::POS_FIRST: begin
            push(char_of(b[7:2]), 1'b0, 1'b0);
            held = {16'b0, b[1:0]};
            group_pos = b64sc_pkg::POS_SECOND;
            if (last_flag) begin
               push(char_of({held[1:0], 4'b0000}), 1'b0, 1'b0);
               push(b64sc_pkg::PAD_CHAR, 1'b0, 1'b0);
               push(b64sc_pkg::PAD_CHAR, 1'b0, 1'b1);
            end
         end
         b64sc_pkg::POS_SECOND: begin
            v10 = {held[1:0], b};
            push(char_of(v10[9:4]), 1'b0, 1'b0);
            held = {14'b0, v10[3:0]};
            group_pos = b64sc_pkg::POS_THIRD;
            if (last_flag) begin
               push(char_of({v10[3:0], 2'b00}), 1'b0, 1'b0);
               push(b64sc_pkg::PAD_CHAR, 1'b0, 1'b1);
            end
         end
         default: begin
            v12 = {held[3:0], b};
            push(char_of(v12[11:6]), 1'b0, 1'b0);
            push(char_of(v12[5:0]), 1'b0, last_flag);
            held = '0;
            group_pos = b64sc_pkg::POS_FIRST;
         end
      endcase
      if (last_flag) clear_stream();
   endfunction

   function void decode_char(logic [7:0] c, logic last_flag);
      logic        ok;
      logic [5:0]  six;
      logic [23:0] word;
      int          idx;
      ok = 1'b0;
      six = '0;
      for (idx = 0; idx < 64; idx++) begin
         if (alphabet[idx] == c) begin
            ok = 1'b1;
            six = 6'(idx);
         end
      end
      // after an error only the closing beat produces output
      if (error_seen) begin
         if (last_flag) begin
            push(8'h00, 1'b1, 1'b1);
            clear_stream();
         end
         return;
      end
      if (group_pos != b64sc_pkg::POS_FOURTH) begin
         if (last_flag) begin
            push(8'h00, 1'b1, 1'b1);
            clear_stream();
            return;
         end
         case (group_pos)
            b64sc_pkg::POS_FIRST:  held[17:12] = six;
            b64sc_pkg::POS_SECOND: held[11:6] = six;
            default:               held[5:0] = six;
         endcase
         held_ok[group_pos] = ok;
         group_pos = group_pos + 2'd1;
         return;
      end
      if (held_ok[1:0] != 2'b11) begin
         push(8'h00, 1'b1, last_flag);
         clear_stream();
         if (!last_flag) error_seen = 1'b1;
         return;
      end
      word = {held, six};
      push(word[23:16], 1'b0, (!held_ok[2] && !ok) ? last_flag : 1'b0);
      if (held_ok[2]) push(word[15:8], 1'b0, !ok ? last_flag : 1'b0);
      if (ok) push(word[7:0], 1'b0, last_flag);
      clear_stream();
   endfunction

   function void note_input(logic [7:0] value, logic last_flag);
      if (direction == b64sc_pkg::DIR_ENCODE) encode_byte(value, last_flag);
      else decode_char(value, last_flag);
   endfunction

   function void check_result(logic [7:0] data, logic err, logic last_flag);
      codec_beat_type got;
      codec_beat_type want;
      got.data = data;
      got.err = err;
      got.last = last_flag;
      if (expected_beats.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: unexpected beat data=%02h err=%0b last=%0b",
                     data, err, last_flag);
      end else begin
         want = expected_beats.pop_front();
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected data=%02h err=%0b last=%0b,",
                         " got data=%02h err=%0b last=%0b"},
                        want.data, want.err, want.last, got.data, got.err, got.last);
         end
      end
   endfunction
endclass

module testbench;

   localparam logic [2:0] DIRECTION_ADDR = 3'd0;
   localparam int SETTLE_CYCLES = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 25;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_byte
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] out_byte
   logic        rsp_tuser;   // [0] out_error
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   base64_scoreboard sb;
   logic [7:0]       message_bytes[$];
   int               tx_idle_pct;
   int               rx_idle_pct;
   int               hold_request;
   int               hold_left;
   int               idle_cycles;

   base64_stream_codec dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_request > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_request - 1;
         hold_request = 0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_input(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   task automatic send_beat(input logic [7:0] value, input logic last_flag);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= last_flag;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_message();
      int i;
      for (i = 0; i < message_bytes.size(); i++)
         send_beat(message_bytes[i], i == message_bytes.size() - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_direction(input logic value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= DIRECTION_ADDR;
      csr_pwdata <= {31'b0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_direction(value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic load_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) message_bytes.push_back(s[i]);
   endtask

   task automatic build_encode_message();
      message_bytes.delete();
      repeat ($urandom_range(1, 9)) message_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // mostly well-formed groups; some noise, bad characters and short tails
   task automatic build_decode_message();
      int kind;
      int n;
      message_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 6)) message_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 3) * 4) begin
            if ($urandom_range(0, 99) < 6)
               message_bytes.push_back($urandom_range(0, 1) ? b64sc_pkg::PAD_CHAR
                  : 8'($urandom_range(0, 255)));
            else
               message_bytes.push_back(sb.char_of(6'($urandom_range(0, 63))));
         end
         n = message_bytes.size();
         if ($urandom_range(0, 99) < 30) begin
            message_bytes[n - 1] = b64sc_pkg::PAD_CHAR;
            if ($urandom_range(0, 1)) message_bytes[n - 2] = b64sc_pkg::PAD_CHAR;
         end
         if (kind >= 90) repeat ($urandom_range(1, 3)) void'(message_bytes.pop_back());
      end
   endtask

   initial begin
      int mode;
      int d;
      int phase_items;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      tx_idle_pct = 12;
      rx_idle_pct = 87;
      hold_request = 0;
      hold_left = 0;
      idle_cycles = 0;
      sb = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: encode flush after one, two and three bytes
      write_direction(b64sc_pkg::DIR_ENCODE);
      message_bytes.delete();
      message_bytes.push_back(8'h00);
      send_message();
      message_bytes.delete();
      message_bytes.push_back(8'hFF);
      message_bytes.push_back(8'hFF);
      send_message();
      message_bytes.delete();
      message_bytes.push_back(8'h00);
      message_bytes.push_back(8'hFF);
      message_bytes.push_back(8'h80);
      send_message();
      wait_drained();

      // directed: padding forms, bad groups, dropped tail, bad length
      write_direction(b64sc_pkg::DIR_DECODE);
      message_bytes.delete();
      load_text("TWE=TQ==");
      send_message();
      message_bytes.delete();
      load_text("TWFu=");
      message_bytes.push_back(8'h00);
      load_text("A/");
      message_bytes.push_back(8'hFF);
      send_message();
      message_bytes.delete();
      load_text("AB");
      send_message();
      wait_drained();

      for (mode = 0; mode < 3; mode++) begin
         tx_idle_pct = (mode == 0) ? 12 : (mode == 1) ? 87 : 0;
         rx_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 12 : 0;
         for (d = 0; d < 2; d++) begin
            wait_drained();
            write_direction(d ? b64sc_pkg::DIR_DECODE : b64sc_pkg::DIR_ENCODE);
            if (mode == 2 && d == 0) hold_request = HOLD_CYCLES;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
               if (d) build_decode_message();
               else build_encode_message();
               send_message();
               phase_items += message_bytes.size();
               if ($urandom_range(0, 9) == 0) wait_drained();
            end
         end
      end

      wait_drained();
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

/* base64_stream_codec.f */
sv/b64sc_pkg.sv
sv/b64sc_core.sv
sv/b64sc_emit.sv
sv/base64_stream_codec.sv
sv/b64sc_checker.sv
tb/testbench.sv
